// ===== src/pip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the even-odd point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
   localparam int COUNT_WIDTH  = 2;
   localparam logic [COUNT_WIDTH-1:0] MIN_VERTICES = COUNT_WIDTH'(3);

   localparam logic KIND_QUERY  = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic      kind;
      coord_type coord_x;
      coord_type coord_y;
      logic      last;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic too_few;
   } rsp_type;

endpackage

// ===== src/point_in_polygon_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Even-odd ray-crossing test of a query point against a streamed polygon.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  pip_pkg::req_type (query point or vertex)
//   rsp      out  rsp_valid/rsp_ready  pip_pkg::rsp_type (inside_res, too_few)
//
// one beat per cycle unless a last-vertex beat stalls; a beat is registered,
// then tested from that register against the stored previous and first vertex
// (an edge test each, four 17x17 multiplies); a last vertex registers rsp_valid.
// synchronous reset clears the control state and the stored coordinates.
// a waiting result stalls only a last-vertex beat; other beats keep flowing.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pip_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pip_pkg::rsp_type  rsp_data
);

   localparam int DW = pip_pkg::DIFF_WIDTH;
   localparam int PW = pip_pkg::PROD_WIDTH;
   localparam int CW = pip_pkg::COUNT_WIDTH;

   function automatic logic edge_hit(
      input pip_pkg::coord_type xi,
      input pip_pkg::coord_type yi,
      input pip_pkg::coord_type xj,
      input pip_pkg::coord_type yj,
      input pip_pkg::coord_type px,
      input pip_pkg::coord_type py
   );
      logic                 straddle;
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] dpx;
      logic signed [DW-1:0] dxj;
      logic signed [DW-1:0] dpy;
      logic signed [PW-1:0] lhs;
      logic signed [PW-1:0] rhs;
      logic                 hit;
      straddle = (yi > py) != (yj > py);
      d   = DW'(yj) - DW'(yi);
      dpx = DW'(px) - DW'(xi);
      dxj = DW'(xj) - DW'(xi);
      dpy = DW'(py) - DW'(yi);
      lhs = PW'(dpx) * PW'(d);
      rhs = PW'(dxj) * PW'(dpy);
      hit = d[DW-1] ? (rhs < lhs) : (lhs < rhs);
      return straddle && hit;
   endfunction

   logic                 in_valid_ff;
   pip_pkg::req_type     in_ff;
   pip_pkg::coord_type   qx_ff, qy_ff, fx_ff, fy_ff, vx_ff, vy_ff;
   logic                 parity_ff;
   logic [CW-1:0]        seen_ff;
   logic                 rsp_valid_ff;
   pip_pkg::rsp_type     rsp_ff;

   logic                 is_vertex;
   logic                 emits;
   logic                 advance;
   logic                 hit_prev;
   logic                 hit_close;
   logic [CW-1:0]        seen_in;
   logic                 parity_in;
   logic                 rsp_valid_in;

   assign is_vertex = in_ff.kind == pip_pkg::KIND_VERTEX;
   assign emits     = in_valid_ff && is_vertex && in_ff.last;
   assign advance   = in_valid_ff && (!emits || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign hit_prev  = (seen_ff != '0) &&
                      edge_hit(in_ff.coord_x, in_ff.coord_y, vx_ff, vy_ff, qx_ff, qy_ff);
   assign hit_close = edge_hit(fx_ff, fy_ff, in_ff.coord_x, in_ff.coord_y, qx_ff, qy_ff);

   always_comb begin
      seen_in   = (seen_ff < pip_pkg::MIN_VERTICES) ? seen_ff + CW'(1) : seen_ff;
      parity_in = parity_ff ^ hit_prev;
   end

   assign rsp_valid_in = (advance && emits) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         parity_ff    <= 1'b0;
         seen_ff      <= '0;
         qx_ff        <= '0;
         qy_ff        <= '0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         vx_ff        <= '0;
         vy_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            if (!is_vertex) begin
               qx_ff     <= in_ff.coord_x;
               qy_ff     <= in_ff.coord_y;
               parity_ff <= 1'b0;
               seen_ff   <= '0;
            end else begin
               if (seen_ff == '0) begin
                  fx_ff <= in_ff.coord_x;
                  fy_ff <= in_ff.coord_y;
               end
               vx_ff <= in_ff.coord_x;
               vy_ff <= in_ff.coord_y;
               if (in_ff.last) begin
                  parity_ff <= 1'b0;
                  seen_ff   <= '0;
               end else begin
                  parity_ff <= parity_in;
                  seen_ff   <= seen_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
      if (advance && emits) begin
         if (seen_in < pip_pkg::MIN_VERTICES) begin
            rsp_ff.inside_res <= 1'b0;
            rsp_ff.too_few    <= 1'b1;
         end else begin
            rsp_ff.inside_res <= parity_in ^ hit_close;
            rsp_ff.too_few    <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.inside_res && rsp_ff.too_few))
      else $error("inside and too_few both set");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (advance && emits) |=> (seen_ff == '0 && !parity_ff && rsp_valid_ff))
      else $error("polygon state not cleared after result");

   a_hold_stalled_beat: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_ff)))
      else $error("stalled beat lost");

   a_query_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_vertex) |=> (seen_ff == '0 && !parity_ff))
      else $error("query load did not clear polygon state");
`endif

endmodule

// ===== bench/point_in_polygon_test_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_top_tb
// Self-checking bench for the streamed even-odd point-in-polygon block. A
// scoreboard tracks the query point, the first and previous vertex, the
// crossing parity and the vertex count. It predicts one inside/too-few verdict
// per closing vertex and compares each verdict the block returns, in order.
// Stimulus is a directed set of corner polygons followed by random polygons
// with some noise, run under several sender and receiver throttling phases.
// ----------------------------------------------------------------------------

class polygon_scoreboard;

   longint query_x, query_y;
   longint first_x, first_y;
   longint prev_x, prev_y;
   bit     parity;
   int     seen;
   int     errors;
   pip_pkg::rsp_type verdict_q[$];

   function new();
      query_x = 0; query_y = 0;
      first_x = 0; first_y = 0;
      prev_x = 0; prev_y = 0;
      parity = 1'b0;
      seen = 0;
      errors = 0;
   endfunction

   // edge from j (earlier) to i (later), exact cross-multiplied compare
   function void cross_edge(longint xi, longint yi, longint xj, longint yj);
      longint span, lhs, rhs;
      bit     hit;
      if ((yi > query_y) == (yj > query_y))
         return;
      span = yj - yi;
      lhs = (query_x - xi) * span;
      rhs = (xj - xi) * (query_y - yi);
      hit = (span > 0) ? (lhs < rhs) : (rhs < lhs);
      if (hit)
         parity = !parity;
   endfunction

   function void note_beat(pip_pkg::req_type beat);
      longint x, y;
      pip_pkg::rsp_type verdict;
      x = beat.coord_x;
      y = beat.coord_y;
      if (beat.kind == pip_pkg::KIND_QUERY) begin
         query_x = x;
         query_y = y;
         parity = 1'b0;
         seen = 0;
         return;
      end
      if (seen == 0) begin
         first_x = x;
         first_y = y;
      end else begin
         cross_edge(x, y, prev_x, prev_y);
      end
      prev_x = x;
      prev_y = y;
      if (seen < int'(pip_pkg::MIN_VERTICES))
         seen++;
      if (!beat.last)
         return;
      if (seen < int'(pip_pkg::MIN_VERTICES)) begin
         verdict.inside_res = 1'b0;
         verdict.too_few = 1'b1;
      end else begin
         cross_edge(first_x, first_y, x, y);
         verdict.inside_res = parity;
         verdict.too_few = 1'b0;
      end
      verdict_q = {verdict_q, verdict};
      parity = 1'b0;
      seen = 0;
   endfunction

   function void report(string what);
      errors++;
      if (errors <= 10)
         $display("%t mismatch: %s", $realtime, what);
   endfunction

   function void check_beat(pip_pkg::rsp_type got);
      pip_pkg::rsp_type want;
      if (verdict_q.size() == 0) begin
         report($sformatf("unexpected verdict inside_res=%0b too_few=%0b",
                          got.inside_res, got.too_few));
         return;
      end
      want = verdict_q.pop_front();
      if (got.inside_res !== want.inside_res)
         report($sformatf("inside_res expected %0b actual %0b",
                          want.inside_res, got.inside_res));
      if (got.too_few !== want.too_few)
         report($sformatf("too_few expected %0b actual %0b",
                          want.too_few, got.too_few));
   endfunction

   function void flush_leftovers();
      while (verdict_q.size() != 0) begin
         void'(verdict_q.pop_front());
         report("verdict never returned");
      end
   endfunction

endclass

module point_in_polygon_test_top_tb;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   pip_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   pip_pkg::rsp_type rsp_data;

   polygon_scoreboard sb = new();

   int idle_pct;
   int stall_pct;
   bit hold_req;
   bit offer_lowered;
   int quiet_cycles;

   point_in_polygon_test_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_beat(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_beat(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("point_in_polygon_test_top_tb: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !reset) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic pip_pkg::req_type pack_beat(logic kind, longint x, longint y,
                                                  logic last);
      pip_pkg::req_type beat;
      beat.kind = kind;
      beat.coord_x = pip_pkg::coord_type'(x);
      beat.coord_y = pip_pkg::coord_type'(y);
      beat.last = last;
      return beat;
   endfunction

   function automatic longint near_coord(longint center, int spread);
      longint v;
      if (spread >= 32768)
         return longint'(pip_pkg::coord_type'($urandom));
      v = center + longint'($urandom_range(2 * spread)) - spread;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v;
   endfunction

   task automatic send_beat(pip_pkg::req_type beat);
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      offer_lowered = 1'b0;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         offer_lowered = 1'b1;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_for_verdicts();
      if (!offer_lowered)
         req_valid <= 1'b0;
      offer_lowered = 1'b1;
      @(posedge clock);
      while (sb.verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      // vertices before any query point, tested against the origin
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, -10, -10, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 10, -10, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 0, 10, 1'b1));
      // single vertex polygon
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 5, 5, 1'b1));
      // query with last set, last ignored
      send_beat(pack_beat(pip_pkg::KIND_QUERY, 0, 0, 1'b1));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, -32768, -32768, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 32767, -32768, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 32767, 32767, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, -32768, 32767, 1'b1));
      // query in the full-range corner
      send_beat(pack_beat(pip_pkg::KIND_QUERY, -32768, 32767, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, -32768, -32768, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 32767, -32768, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 32767, 32767, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, -32768, 32767, 1'b1));
      // two vertex polygon
      send_beat(pack_beat(pip_pkg::KIND_QUERY, 32767, -32768, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 1, 2, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 3, 4, 1'b1));
      // self-overlapping diamond, vertex count saturates
      send_beat(pack_beat(pip_pkg::KIND_QUERY, 0, 0, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 0, -5, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 5, 0, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 0, 5, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, -5, 0, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 0, -5, 1'b0));
      send_beat(pack_beat(pip_pkg::KIND_VERTEX, 5, 0, 1'b1));
   endtask

   task automatic run_polygons(int count);
      int     sent;
      int     pick;
      int     verts;
      int     spread;
      bit     broken;
      longint qx, qy;
      sent = 0;
      qx = 0;
      qy = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_beat(pack_beat(1'($urandom), near_coord(0, 32768),
                                near_coord(0, 32768), 1'($urandom)));
            sent++;
         end else begin
            case ($urandom_range(2))
               0: spread = 4;
               1: spread = 64;
               default: spread = 32768;
            endcase
            if ($urandom_range(3) != 0) begin
               qx = near_coord(0, 32768);
               qy = near_coord(0, 32768);
               send_beat(pack_beat(pip_pkg::KIND_QUERY, qx, qy, 1'($urandom)));
               sent++;
            end
            verts = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(10, 3);
            broken = ($urandom_range(19) == 0);
            for (int v = 0; v < verts; v++) begin
               send_beat(pack_beat(pip_pkg::KIND_VERTEX, near_coord(qx, spread),
                                   near_coord(qy, spread),
                                   (v == verts - 1) && !broken));
               sent++;
            end
         end
      end
      wait_for_verdicts();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_req = 1'b0;
      offer_lowered = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_for_verdicts();

      hold_req = 1'b1;
      run_polygons(250);

      idle_pct = 65;
      run_polygons(250);

      idle_pct = 0;
      stall_pct = 65;
      run_polygons(250);

      idle_pct = 29;
      stall_pct = 29;
      run_polygons(250);

      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flush_leftovers();
      if (sb.errors == 0)
         $display("point_in_polygon_test_top_tb: done, clean");
      else
         $display("point_in_polygon_test_top_tb: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
src/pip_pkg.sv
src/point_in_polygon_test_top.sv
bench/point_in_polygon_test_top_tb.sv
